// ===== hdl/imt_pkg.sv =====
// Package for the interval map table: sizes, codes and shared types.
// Used by imt_ctrl, interval_map_table_top and the testbench files; no dependencies.
`timescale 1ns / 1ps
package imt_pkg;
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = 64;
	localparam int SPAN_W   = 63;
	localparam int VAL_W    = 64;
	localparam int WORD_W   = ADDR_W + SPAN_W + VAL_W;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_FIND   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_CONFLICT    = 3'd1,
		STS_FULL        = 3'd2,
		STS_NOT_REMOVED = 3'd3,
		STS_NOT_FOUND   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCMP, S_DECIDE, S_PROBE, S_CPRD, S_CPWR, S_WRITE, S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] start;
		logic [SPAN_W-1:0] span;
		logic [VAL_W-1:0]  value;
	} res_t;
endpackage

// ===== hdl/imt_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module imt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/imt_ctrl.sv =====
// Sequencer of the interval map table: binary search, tombstone probe,
// slot shifting and updates. Uses imt_pkg; drives the slot RAM.
`timescale 1ns / 1ps
module imt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                action,
	input  logic [imt_pkg::ADDR_W-1:0] address,
	input  logic [imt_pkg::SPAN_W-1:0] span,
	input  logic [imt_pkg::VAL_W-1:0]  tag_value,
	output imt_pkg::ram_req_t         ram_req,
	input  logic [imt_pkg::WORD_W-1:0] ram_rdata,
	output logic                      res_valid,
	input  logic                      res_ready,
	output imt_pkg::res_t             res
);
	import imt_pkg::*;

	state_t            state_q, state_d;
	action_t           act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SPAN_W-1:0] span_q;
	logic [VAL_W-1:0]  tag_q;
	logic [CNT_W-1:0]  used_q, live_q;
	logic [CAPACITY-1:0] busy_q;
	logic [CNT_W-1:0]  lo_q, hp1_q, pos_q, probe_q;
	logic [IDX_W-1:0]  mid_q, at_q, cp_dst_q;
	logic              hit_q, cp_up_q;
	logic [WORD_W-1:0] hd_q;
	res_t              res_q;

	logic [CNT_W:0]    sum_mid, up_sum;
	logic [IDX_W-1:0]  mid_c, cp_src, lo_idx;
	logic [ADDR_W-1:0] r_start, diff;
	logic [SPAN_W-1:0] r_span;
	logic              c_lt, c_gt, c_eq;
	logic [CNT_W-1:0]  new_lo, new_hp1, miss_pos, sz, pos_lo;
	logic              pos_ge, pos_busy, hit_busy;
	logic              lo_ok, up_ok, grow_ok, cp_more;

	// search midpoint and compare unit
	assign sum_mid = {1'b0, lo_q} + {1'b0, hp1_q} - 1'b1;
	assign mid_c   = sum_mid[IDX_W:1];
	assign r_start = ram_rdata[WORD_W-1 -: ADDR_W];
	assign r_span  = ram_rdata[VAL_W +: SPAN_W];
	assign diff    = addr_q - r_start;
	assign c_lt    = addr_q < r_start;
	assign c_gt    = busy_q[mid_q] ? (diff >= {1'b0, r_span}) : (addr_q > r_start);
	assign c_eq    = !c_lt && !c_gt;
	assign new_hp1 = c_lt ? CNT_W'(mid_q) : hp1_q;
	assign new_lo  = c_lt ? lo_q : CNT_W'(mid_q) + 1'b1;
	assign miss_pos = c_lt ? CNT_W'(mid_q) : CNT_W'(mid_q) + 1'b1;

	assign pos_ge   = pos_q >= used_q;
	assign pos_busy = !pos_ge && busy_q[pos_q[IDX_W-1:0]];
	assign hit_busy = hit_q && pos_busy;

	// nearest tombstone probe, one distance per cycle
	assign pos_lo  = pos_q - probe_q;
	assign lo_idx  = pos_lo[IDX_W-1:0];
	assign sz      = (pos_q > used_q - pos_q) ? pos_q : used_q - pos_q;
	assign up_sum  = {1'b0, pos_q} + {1'b0, probe_q};
	assign lo_ok   = (pos_q >= probe_q) && !busy_q[lo_idx];
	assign up_ok   = (up_sum < {1'b0, used_q}) && !busy_q[up_sum[IDX_W-1:0]];
	assign grow_ok = (used_q < CNT_W'(CAPACITY)) && (up_sum == {1'b0, used_q});

	assign cp_src  = cp_up_q ? cp_dst_q - 1'b1 : cp_dst_q + 1'b1;
	assign cp_more = cp_up_q ? (CNT_W'(cp_dst_q) > pos_q + 1'b1)
	                         : (CNT_W'(cp_dst_q) + 2'd2 < pos_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (action_t'(action) == ACT_NONE) state_d = S_DONE;
					else if (used_q == '0) state_d = S_DECIDE;
					else state_d = S_SRD;
				end
			end
			S_SRD: state_d = S_SCMP;
			S_SCMP: begin
				if (c_eq || !(new_lo < new_hp1)) state_d = S_DECIDE;
				else state_d = S_SRD;
			end
			S_DECIDE: begin
				if (act_q == ACT_ADD && !hit_busy) begin
					if (live_q >= used_q) begin
						if (used_q >= CNT_W'(CAPACITY)) state_d = S_DONE;
						else if (used_q > pos_q) state_d = S_CPRD;
						else state_d = S_WRITE;
					end else if (pos_ge || pos_busy) begin
						state_d = S_PROBE;
					end else begin
						state_d = S_WRITE;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_PROBE: begin
				if (probe_q > sz) state_d = S_DONE;
				else if (lo_ok) state_d = (probe_q > CNT_W'(1)) ? S_CPRD : S_WRITE;
				else if (up_ok || grow_ok) state_d = S_CPRD;
			end
			S_CPRD: state_d = S_CPWR;
			S_CPWR: state_d = cp_more ? S_CPRD : S_WRITE;
			S_WRITE: state_d = S_DONE;
			S_DONE: if (res_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = at_q;
		ram_req.wdata = {addr_q, span_q, tag_q};
		ram_req.raddr = mid_c;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_DECIDE: begin
				ram_req.waddr = pos_q[IDX_W-1:0];
				ram_req.wdata = {hd_q[WORD_W-1 -: ADDR_W], {(SPAN_W + VAL_W){1'b0}}};
				ram_req.we    = (act_q == ACT_REMOVE) && hit_busy;
			end
			S_CPRD: ram_req.raddr = cp_src;
			S_CPWR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cp_dst_q;
				ram_req.wdata = ram_rdata;
			end
			S_WRITE: ram_req.we = 1'b1;
			S_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			live_q  <= '0;
			busy_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_DECIDE: begin
					if (act_q == ACT_REMOVE && hit_busy) begin
						busy_q[pos_q[IDX_W-1:0]] <= 1'b0;
						live_q <= live_q - 1'b1;
					end
					if (act_q == ACT_ADD && !hit_busy && live_q >= used_q &&
					    used_q < CNT_W'(CAPACITY)) begin
						used_q <= used_q + 1'b1;
					end
				end
				S_PROBE: begin
					if (!(probe_q > sz) && !lo_ok && !up_ok && grow_ok) begin
						used_q <= used_q + 1'b1;
					end
				end
				S_CPWR: busy_q[cp_dst_q] <= busy_q[cp_src];
				S_WRITE: begin
					busy_q[at_q] <= 1'b1;
					live_q <= live_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q   <= action_t'(action);
				addr_q  <= address;
				span_q  <= span;
				tag_q   <= tag_value;
				lo_q    <= '0;
				hp1_q   <= used_q;
				pos_q   <= '0;
				hit_q   <= 1'b0;
				probe_q <= CNT_W'(1);
				res_q   <= '{STS_NOT_FOUND, '0, '0, '0};
			end
			S_SRD: mid_q <= mid_c;
			S_SCMP: begin
				hd_q  <= ram_rdata;
				lo_q  <= new_lo;
				hp1_q <= new_hp1;
				hit_q <= c_eq;
				pos_q <= c_eq ? CNT_W'(mid_q) : miss_pos;
			end
			S_DECIDE: begin
				cp_up_q  <= 1'b1;
				cp_dst_q <= used_q[IDX_W-1:0];
				at_q     <= pos_q[IDX_W-1:0];
				unique case (act_q)
					ACT_FIND: begin
						if (hit_busy) begin
							res_q.status <= STS_OK;
							res_q.start  <= hd_q[WORD_W-1 -: ADDR_W];
							res_q.span   <= hd_q[VAL_W +: SPAN_W];
							res_q.value  <= hd_q[VAL_W-1:0];
						end
					end
					ACT_REMOVE: res_q.status <= hit_busy ? STS_OK : STS_NOT_REMOVED;
					ACT_ADD: begin
						if (hit_busy) res_q.status <= STS_CONFLICT;
						else if (live_q >= used_q && used_q >= CNT_W'(CAPACITY))
							res_q.status <= STS_FULL;
					end
					default: ;
				endcase
			end
			S_PROBE: begin
				probe_q <= probe_q + 1'b1;
				if (probe_q > sz) begin
					res_q.status <= STS_FULL;
				end else if (lo_ok) begin
					cp_up_q  <= 1'b0;
					cp_dst_q <= lo_idx;
					at_q     <= pos_q[IDX_W-1:0] - 1'b1;
				end else if (up_ok) begin
					cp_up_q  <= 1'b1;
					cp_dst_q <= up_sum[IDX_W-1:0];
				end else if (grow_ok) begin
					cp_up_q  <= 1'b1;
					cp_dst_q <= used_q[IDX_W-1:0];
				end
			end
			S_CPWR: cp_dst_q <= cp_up_q ? cp_dst_q - 1'b1 : cp_dst_q + 1'b1;
			S_WRITE: res_q.status <= STS_OK;
			default: ;
		endcase
	end
endmodule

// ===== hdl/interval_map_table_top.sv =====
// Top level of the interval map table: sequencer, slot RAM, result register.
// Depends on imt_pkg, imt_ctrl and imt_ram.
`timescale 1ns / 1ps
// A sorted table of up to 64 address intervals (start, span, value), one
// operation per input transfer: add, remove covering interval, find
// covering interval or none; every transfer yields one result transfer.
// The block handles one item at a time: in_ready is high only while the
// sequencer is idle. An item passes through acceptance, a binary search
// (up to log2(slots in use)+1 steps, each a slot RAM read and a compare),
// the decision, then for an add a tombstone probe, one distance at a time,
// and slot moves, each a read and a write on the single slot RAM port
// pair, then the final write and the hand-off. A finished result waits in
// an output register, so the next item may be accepted while it is not
// yet taken. Slot contents need no clearing after reset; busy bits reset
// to zero.
module interval_map_table_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [imt_pkg::ADDR_W-1:0] address,
	input  logic [imt_pkg::SPAN_W-1:0] span,
	input  logic [imt_pkg::VAL_W-1:0]  tag_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [imt_pkg::ADDR_W-1:0] hit_start,
	output logic [imt_pkg::SPAN_W-1:0] hit_span,
	output logic [imt_pkg::VAL_W-1:0]  hit_value
);
	import imt_pkg::*;

	ram_req_t          ram_req;
	logic [WORD_W-1:0] ram_rdata;
	logic              res_valid, res_ready;
	res_t              res, out_q;
	logic              out_valid_q;

	imt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.address   (address),
		.span      (span),
		.tag_value (tag_value),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// slot storage: start, span and value packed in one word per slot
	imt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// result register: loads when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign hit_start = out_q.start;
	assign hit_span  = out_q.span;
	assign hit_value = out_q.value;

`ifndef SYNTH
	// the sequencer is busy in the cycle after a transfer is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// hit fields are zero on every result but a successful find
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_OK |->
		hit_start == '0 && hit_span == '0 && hit_value == '0)
		else $error("nonzero hit fields on a failing result");

	// after handing off a result the sequencer is idle again
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> in_ready)
		else $error("sequencer not idle after result hand-off");
`endif
endmodule

// ===== tb/interval_map_table_checker.sv =====
// Checker for the interval map table: watches both channels, predicts each result.
// Depends on imt_pkg; instantiated next to the block by interval_map_table_top_tb.
`timescale 1ns / 1ps
module interval_map_table_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [imt_pkg::ADDR_W-1:0] address,
	input  logic [imt_pkg::SPAN_W-1:0] span,
	input  logic [imt_pkg::VAL_W-1:0]  tag_value,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [2:0]                 status,
	input  logic [imt_pkg::ADDR_W-1:0] hit_start,
	input  logic [imt_pkg::SPAN_W-1:0] hit_span,
	input  logic [imt_pkg::VAL_W-1:0]  hit_value,
	output int                         fail_count,
	output int                         pending_count,
	output int                         live_entries
);
	import imt_pkg::*;

	logic [ADDR_W-1:0] tbl_start [CAPACITY];
	logic [SPAN_W-1:0] tbl_span  [CAPACITY];
	logic [VAL_W-1:0]  tbl_value [CAPACITY];
	logic              tbl_busy  [CAPACITY];
	int                used;
	int                live;
	res_t              pending_results [$];

	assign pending_count = pending_results.size();
	assign live_entries  = live;

	// -1 below, 0 covered, 1 above; tombstones match only their start
	function automatic int slot_order(logic [ADDR_W-1:0] a, int s);
		if (a < tbl_start[s])
			return -1;
		if (tbl_busy[s])
			return ((a - tbl_start[s]) >= {1'b0, tbl_span[s]}) ? 1 : 0;
		return (a > tbl_start[s]) ? 1 : 0;
	endfunction

	function automatic bit locate(logic [ADDR_W-1:0] a, output int pos);
		int lo, hi, mid, c;
		lo = 0;
		hi = used - 1;
		mid = 0;
		c = 0;
		pos = 0;
		if (used == 0)
			return 0;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			c = slot_order(a, mid);
			if (c == 0) begin
				pos = mid;
				return 1;
			end
			if (c < 0)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		pos = (c < 0) ? mid : mid + 1;
		return 0;
	endfunction

	function automatic void move_slot(int dst, int src);
		tbl_start[dst] = tbl_start[src];
		tbl_span[dst]  = tbl_span[src];
		tbl_value[dst] = tbl_value[src];
		tbl_busy[dst]  = tbl_busy[src];
	endfunction

	function automatic void open_gap(int idx, int take);
		for (int j = take; j > idx; j--)
			move_slot(j, j - 1);
	endfunction

	function automatic status_t insert_interval(logic [ADDR_W-1:0] a,
			logic [SPAN_W-1:0] sp, logic [VAL_W-1:0] v);
		int  idx, at, sz, top;
		bit  hit, done;
		hit = locate(a, idx);
		at = 0;
		if (hit && tbl_busy[idx])
			return STS_CONFLICT;
		if (live >= used) begin
			if (used >= CAPACITY)
				return STS_FULL;
			top = used;
			used++;
			open_gap(idx, top);
			at = idx;
		end else if (idx >= used || tbl_busy[idx]) begin
			top = used;
			sz = (idx > top - idx) ? idx : top - idx;
			done = 0;
			for (int i = 1; i <= sz && !done; i++) begin
				if (idx >= i && !tbl_busy[idx - i]) begin
					for (int j = idx - i; j + 1 < idx; j++)
						move_slot(j, j + 1);
					at = idx - 1;
					done = 1;
				end else if (idx + i < top && !tbl_busy[idx + i]) begin
					open_gap(idx, idx + i);
					at = idx;
					done = 1;
				end else if (top < CAPACITY && idx + i == top) begin
					used++;
					open_gap(idx, top);
					at = idx;
					done = 1;
				end
			end
			if (!done)
				return STS_FULL;
		end else begin
			at = idx;
		end
		tbl_busy[at]  = 1;
		tbl_start[at] = a;
		tbl_span[at]  = sp;
		tbl_value[at] = v;
		live++;
		return STS_OK;
	endfunction

	function automatic res_t apply_request(logic [1:0] act, logic [ADDR_W-1:0] a,
			logic [SPAN_W-1:0] sp, logic [VAL_W-1:0] v);
		res_t r;
		int   idx;
		r = '0;
		r.status = STS_NOT_FOUND;
		case (act)
			ACT_ADD: r.status = insert_interval(a, sp, v);
			ACT_REMOVE: begin
				if (locate(a, idx) && tbl_busy[idx]) begin
					tbl_busy[idx]  = 0;
					tbl_span[idx]  = '0;
					tbl_value[idx] = '0;
					live--;
					r.status = STS_OK;
				end else
					r.status = STS_NOT_REMOVED;
			end
			ACT_FIND: begin
				if (locate(a, idx) && tbl_busy[idx]) begin
					r.status = STS_OK;
					r.start  = tbl_start[idx];
					r.span   = tbl_span[idx];
					r.value  = tbl_value[idx];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			fail_count <= 0;
			used = 0;
			live = 0;
			for (int i = 0; i < CAPACITY; i++) begin
				tbl_busy[i]  = 0;
				tbl_start[i] = '0;
				tbl_span[i]  = '0;
				tbl_value[i] = '0;
			end
			pending_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result transfer, status %0d", $time, status);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status || hit_start !== want.start ||
							hit_span !== want.span || hit_value !== want.value) begin
						$display("%0t: mismatch expected %0d %h %h %h actual %0d %h %h %h",
							$time, want.status, want.start, want.span, want.value,
							status, hit_start, hit_span, hit_value);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(apply_request(action, address, span, tag_value));
		end
	end
endmodule

// ===== tb/interval_map_table_top_tb.sv =====
// Testbench top for interval_map_table_top: drives requests, stalls results,
// gives the verdict. Depends on imt_pkg, the block and interval_map_table_checker.
`timescale 1ns / 1ps
module interval_map_table_top_tb;
	import imt_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_ready;
	logic [1:0]        action = ACT_FIND;
	logic [ADDR_W-1:0] address = '0;
	logic [SPAN_W-1:0] span = '0;
	logic [VAL_W-1:0]  tag_value = '0;
	logic              out_valid;
	logic              out_ready = 0;
	logic [2:0]        status;
	logic [ADDR_W-1:0] hit_start;
	logic [SPAN_W-1:0] hit_span;
	logic [VAL_W-1:0]  hit_value;
	int                fail_count, pending_count, live_entries;
	bit                drain_stalls = 1;

	// Starts recently added, reused so finds and removes hit real intervals.
	logic [ADDR_W-1:0] known_starts [$];
	logic [SPAN_W-1:0] known_spans  [$];

	always #5 clk = ~clk;

	interval_map_table_top u_top (.*);

	interval_map_table_checker u_chk (.*);

	// Mostly short gaps, now and then a long one, sometimes none at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// One transfer on the request channel; valid stays up until accepted.
	// With no gap, valid stays high into the next transfer.
	task automatic send_request(logic [1:0] act, logic [ADDR_W-1:0] a,
			logic [SPAN_W-1:0] sp, logic [VAL_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		action    <= act;
		address   <= a;
		span      <= sp;
		tag_value <= v;
		in_valid  <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (act == ACT_ADD) begin
			known_starts.push_back(a);
			known_spans.push_back(sp);
			if (known_starts.size() > 96) begin
				void'(known_starts.pop_front());
				void'(known_spans.pop_front());
			end
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Addresses mostly near known starts or in a small window so intervals collide and cover.
	function automatic logic [ADDR_W-1:0] pick_addr();
		int k, r;
		r = $urandom_range(0, 99);
		if (known_starts.size() > 0 && r < 55) begin
			k = $urandom_range(0, known_starts.size() - 1);
			case ($urandom_range(0, 3))
				0: return known_starts[k];
				1: return known_starts[k] + known_spans[k];
				2: return known_starts[k] + known_spans[k] - 1;
				default: return known_starts[k] + $urandom_range(0, 20);
			endcase
		end
		if (r < 90)
			return 64'h1000 + $urandom_range(0, 4000);
		return rand64();
	endfunction

	// Result side stalls at random, with quiet stretches.
	always @(negedge clk) begin
		if (drain_stalls && $urandom_range(0, 99) < 35)
			out_ready <= 0;
		else
			out_ready <= 1;
	end

	initial begin
		logic [1:0] act;
		int         r;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: empty table, field extremes, zero span, tombstone cases.
		send_request(ACT_FIND, 64'h0, '0, '0);
		send_request(ACT_REMOVE, 64'h0, '0, '0);
		send_request(ACT_ADD, 64'h0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(ACT_FIND, 64'h0, '0, '0);
		send_request(ACT_ADD, 64'h0, 63'h5, 64'h1);
		send_request(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, {SPAN_W{1'b1}}, 64'hA5A5);
		send_request(ACT_FIND, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
		send_request(ACT_ADD, 64'h100, 63'h10, 64'h22);
		send_request(ACT_ADD, 64'h108, 63'h40, 64'h33);
		send_request(ACT_FIND, 64'h10F, '0, '0);
		send_request(ACT_FIND, 64'h110, '0, '0);
		send_request(ACT_REMOVE, 64'h104, '0, '0);
		send_request(ACT_REMOVE, 64'h100, '0, '0);
		send_request(ACT_REMOVE, 64'h104, '0, '0);
		send_request(ACT_ADD, 64'h100, 63'h8, 64'h44);
		send_request(ACT_REMOVE, 64'h100, '0, '0);
		send_request(ACT_ADD, 64'h80, 63'h4, 64'h55);
		send_request(ACT_ADD, 64'h200, 63'h4, 64'h66);
		send_request(ACT_NONE, 64'h100, 63'h1, 64'h1);
		send_request(ACT_FIND, 64'h201, '0, '0);

		for (int n = 0; n < 1430; n++) begin
			// Fill hard until full once; pause once for a full drain.
			if (n == 500) begin
				in_valid <= 0;
				while (pending_count != 0)
					@(negedge clk);
				drain_stalls = 0;
			end
			if (n == 700)
				drain_stalls = 1;
			r = $urandom_range(0, 99);
			if ((n >= 300 && n < 450) || r < 45)
				act = ACT_ADD;
			else if (r < 72)
				act = ACT_FIND;
			else if (r < 97)
				act = ACT_REMOVE;
			else
				act = ACT_NONE;
			if (act == ACT_ADD) begin
				r = $urandom_range(0, 9);
				send_request(act, pick_addr(),
					(r < 1) ? '0 : (r < 8) ? SPAN_W'($urandom_range(1, 24)) :
					SPAN_W'(rand64()),
					rand64());
			end else
				send_request(act, pick_addr(), SPAN_W'(rand64()), rand64());
		end

		in_valid <= 0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
